[rtl/core/sd_csd_register_decoder_macros.svh]
// Assertion macros for the SD CSD decoder checker.
// Needs signals named clock and reset in the scope of each use.
`ifndef SD_CSD_REGISTER_DECODER_MACROS_SVH
`define SD_CSD_REGISTER_DECODER_MACROS_SVH

// Concurrent check, switched off while reset is high.
`define SDCSD_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Concurrent check that also runs through reset.
`define SDCSD_ASSERT_NORST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

[rtl/core/sdcsd_pkg.sv]
// Shared types, constants and lookup tables for the SD CSD decoder.
// No dependencies; imported by every stage and the top level.
package sdcsd_pkg;

   // Structure version codes
   localparam logic [1:0] VER_V1 = 2'd0;
   localparam logic [1:0] VER_V2 = 2'd1;

   localparam logic STATUS_OK      = 1'b0;
   localparam logic STATUS_BAD_VER = 1'b1;

   localparam logic [15:0] V2_BLOCK_BYTES = 16'd512;
   // v2: (c_size+1)*512 KB, expressed as a shift before the common /1024
   localparam logic [4:0]  V2_CAP_SHIFT   = 5'd19;
   // v1: multiplier is 2^(size multiplier field + 2)
   localparam logic [4:0]  V1_MULT_BIAS   = 5'd2;
   localparam logic [14:0] NSAC_SCALE     = 15'd100;
   localparam int          CAP_WIDE_W     = 48;
   localparam int          KB_SHIFT       = 10;

   // Transfer speed unit, in bit/s; reserved codes give zero
   function automatic logic [23:0] rate_unit_f(input logic [2:0] code);
      logic [23:0] r;
      case (code)
         3'd0:    r = 24'd10000;
         3'd1:    r = 24'd100000;
         3'd2:    r = 24'd1000000;
         3'd3:    r = 24'd10000000;
         default: r = 24'd0;
      endcase
      return r;
   endfunction

   // TAAC unit already divided by ten (unit code 0 handled apart)
   function automatic logic [19:0] time_tenth_f(input logic [2:0] code);
      logic [19:0] r;
      case (code)
         3'd1:    r = 20'd1;
         3'd2:    r = 20'd10;
         3'd3:    r = 20'd100;
         3'd4:    r = 20'd1000;
         3'd5:    r = 20'd10000;
         3'd6:    r = 20'd100000;
         3'd7:    r = 20'd1000000;
         default: r = 20'd0;
      endcase
      return r;
   endfunction

   // Shared access time / transfer speed value table, scaled by ten
   function automatic logic [6:0] mantissa_f(input logic [3:0] code);
      logic [6:0] r;
      case (code)
         4'd1:    r = 7'd10;
         4'd2:    r = 7'd12;
         4'd3:    r = 7'd13;
         4'd4:    r = 7'd15;
         4'd5:    r = 7'd20;
         4'd6:    r = 7'd25;
         4'd7:    r = 7'd30;
         4'd8:    r = 7'd35;
         4'd9:    r = 7'd40;
         4'd10:   r = 7'd45;
         4'd11:   r = 7'd50;
         4'd12:   r = 7'd55;
         4'd13:   r = 7'd60;
         4'd14:   r = 7'd70;
         4'd15:   r = 7'd80;
         default: r = 7'd0;
      endcase
      return r;
   endfunction

   // ceil(mantissa/10), for the 1 ns unit
   function automatic logic [3:0] ceil_tenth_f(input logic [3:0] code);
      logic [3:0] r;
      case (code)
         4'd1:    r = 4'd1;
         4'd2:    r = 4'd2;
         4'd3:    r = 4'd2;
         4'd4:    r = 4'd2;
         4'd5:    r = 4'd2;
         4'd6:    r = 4'd3;
         4'd7:    r = 4'd3;
         4'd8:    r = 4'd4;
         4'd9:    r = 4'd4;
         4'd10:   r = 4'd5;
         4'd11:   r = 4'd5;
         4'd12:   r = 4'd6;
         4'd13:   r = 4'd6;
         4'd14:   r = 4'd7;
         4'd15:   r = 4'd8;
         default: r = 4'd0;
      endcase
      return r;
   endfunction

   // After field extraction and table lookup
   typedef struct packed {
      logic        status;
      logic        high_capacity;
      logic [21:0] c_size;
      logic [4:0]  cap_shift;
      logic [23:0] rate_unit;
      logic [6:0]  rate_mant;
      logic [2:0]  taac_unit;
      logic [19:0] time_tenth;
      logic [6:0]  time_mant;
      logic [3:0]  taac_ceil;
      logic [7:0]  nsac;
      logic [11:0] command_classes;
      logic [3:0]  read_len_log2;
      logic [3:0]  write_len_log2;
      logic [2:0]  write_speed_factor;
      logic        dsr_present;
   } s1_type;

   // After the products
   typedef struct packed {
      logic        status;
      logic        high_capacity;
      logic [22:0] cap_base;
      logic [4:0]  cap_shift;
      logic [15:0] block_bytes;
      logic [14:0] access_clocks;
      logic [26:0] access_ns;
      logic [29:0] max_rate;
      logic [11:0] command_classes;
      logic [3:0]  read_len_log2;
      logic [3:0]  write_len_log2;
      logic [2:0]  write_speed_factor;
      logic        dsr_present;
   } s2_type;

   // Result beat
   typedef struct packed {
      logic        status;
      logic        high_capacity;
      logic [15:0] block_bytes;
      logic [31:0] capacity_kb;
      logic [14:0] access_clocks;
      logic [26:0] access_ns;
      logic [29:0] max_rate;
      logic [11:0] command_classes;
      logic [3:0]  read_len_log2;
      logic [3:0]  write_len_log2;
      logic [2:0]  write_speed_factor;
      logic        dsr_present;
   } rsp_type;

endpackage

[rtl/core/sd_csd_register_decoder.sv]
// SD card CSD register decoder, top level.
// Depends on sdcsd_pkg, sdcsd_extract, sdcsd_arith and sdcsd_assemble.
//
// Usage:
//  - Request channel (req_): one beat carries a whole 128-bit CSD as two
//    64-bit halves, req_csd_high = bits 127..64, req_csd_low = bits 63..0.
//  - Response channel (rsp_): one beat per request, in order, with the
//    decoded fields. rsp_status = 1 flags a reserved structure version;
//    every other field of that beat is zero.
//  - A beat moves on a rising edge with valid high and stall low.
//  - Stages: three register stages (extract and table lookup, products,
//    capacity shift into the output register); rsp_valid rises once the
//    beat reaches the output register.
//  - Throughput: one beat per cycle sustained without rsp_stall; each stage
//    holds one beat and passes it on whenever the next stage is empty or moving.
//  - rsp_stall backs up through the stages; req_stall rises only once all
//    three hold a beat, so bubbles are squeezed out first. Nothing is lost
//    or repeated under stall and a stalled response stays put.
//  - Reset (synchronous) empties the pipeline; no other state.
module sd_csd_register_decoder
   import sdcsd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_csd_high,
   input  logic [63:0] req_csd_low,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_status,
   output logic        rsp_high_capacity,
   output logic [15:0] rsp_block_bytes,
   output logic [31:0] rsp_capacity_kb,
   output logic [14:0] rsp_access_clocks,
   output logic [26:0] rsp_access_ns,
   output logic [29:0] rsp_max_rate,
   output logic [11:0] rsp_command_classes,
   output logic [3:0]  rsp_read_len_log2,
   output logic [3:0]  rsp_write_len_log2,
   output logic [2:0]  rsp_write_speed_factor,
   output logic        rsp_dsr_present
);

   logic    req_ready;
   logic    s1_valid, s1_ready;
   logic    s2_valid, s2_ready;
   s1_type  s1_data;
   s2_type  s2_data;
   rsp_type rsp_data;

   assign req_stall = !req_ready;

   // Stage 1: slice fields, check version, look up unit/value tables
   sdcsd_extract u_extract (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .csd_high  (req_csd_high),
      .csd_low   (req_csd_low),
      .out_valid (s1_valid),
      .out_ready (s1_ready),
      .out_data  (s1_data)
   );

   // Stage 2: rate, access time and NSAC multiplies
   sdcsd_arith u_arith (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_ready  (s1_ready),
      .in_data   (s1_data),
      .out_valid (s2_valid),
      .out_ready (s2_ready),
      .out_data  (s2_data)
   );

   // Stage 3: capacity, blanking on a bad version, response register
   sdcsd_assemble u_assemble (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid),
      .in_ready  (s2_ready),
      .in_data   (s2_data),
      .out_valid (rsp_valid),
      .out_ready (!rsp_stall),
      .out_data  (rsp_data)
   );

   assign rsp_status             = rsp_data.status;
   assign rsp_high_capacity      = rsp_data.high_capacity;
   assign rsp_block_bytes        = rsp_data.block_bytes;
   assign rsp_capacity_kb        = rsp_data.capacity_kb;
   assign rsp_access_clocks      = rsp_data.access_clocks;
   assign rsp_access_ns          = rsp_data.access_ns;
   assign rsp_max_rate           = rsp_data.max_rate;
   assign rsp_command_classes    = rsp_data.command_classes;
   assign rsp_read_len_log2      = rsp_data.read_len_log2;
   assign rsp_write_len_log2     = rsp_data.write_len_log2;
   assign rsp_write_speed_factor = rsp_data.write_speed_factor;
   assign rsp_dsr_present        = rsp_data.dsr_present;

endmodule

[rtl/core/sdcsd_extract.sv]
// Stage 1 of the CSD decoder: field slicing, version check, table lookups.
// Depends on sdcsd_pkg.
module sdcsd_extract
   import sdcsd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  logic [63:0] csd_high,
   input  logic [63:0] csd_low,
   output logic        out_valid,
   input  logic        out_ready,
   output s1_type      out_data
);

   logic   valid_ff, valid_in;
   s1_type data_ff, data_in;

   logic [1:0] ver;
   logic [7:0] taac, tspeed;
   logic [3:0] rd_len;

   assign ver    = csd_high[63:62];
   assign taac   = csd_high[55:48];
   assign tspeed = csd_high[39:32];
   assign rd_len = csd_high[19:16];

   always_comb begin
      data_in                    = '0;
      data_in.rate_unit          = rate_unit_f(tspeed[2:0]);
      data_in.rate_mant          = mantissa_f(tspeed[6:3]);
      data_in.taac_unit          = taac[2:0];
      data_in.time_tenth         = time_tenth_f(taac[2:0]);
      data_in.time_mant          = mantissa_f(taac[6:3]);
      data_in.taac_ceil          = ceil_tenth_f(taac[6:3]);
      data_in.nsac               = csd_high[47:40];
      data_in.command_classes    = csd_high[31:20];
      data_in.read_len_log2      = rd_len;
      data_in.write_len_log2     = csd_low[25:22];
      data_in.write_speed_factor = csd_low[28:26];
      data_in.dsr_present        = csd_high[12];
      case (ver)
         VER_V1: begin
            data_in.status    = STATUS_OK;
            // C_SIZE straddles the two halves (CSD bits 73..62)
            data_in.c_size    = {10'd0, csd_high[9:0], csd_low[63:62]};
            data_in.cap_shift = {2'd0, csd_low[49:47]} + V1_MULT_BIAS + {1'b0, rd_len};
         end
         VER_V2: begin
            data_in.status        = STATUS_OK;
            data_in.high_capacity = 1'b1;
            data_in.c_size        = {csd_high[5:0], csd_low[63:48]};
            data_in.cap_shift     = V2_CAP_SHIFT;
         end
         default: begin
            data_in.status = STATUS_BAD_VER;
         end
      endcase
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

[rtl/core/sdcsd_arith.sv]
// Stage 2 of the CSD decoder: rate, access time and NSAC products, block size.
// Depends on sdcsd_pkg.
module sdcsd_arith
   import sdcsd_pkg::*;
(
   input  logic   clock,
   input  logic   reset,
   input  logic   in_valid,
   output logic   in_ready,
   input  s1_type in_data,
   output logic   out_valid,
   input  logic   out_ready,
   output s2_type out_data
);

   logic   valid_ff, valid_in;
   s2_type data_ff, data_in;

   logic [29:0] rate_full;
   logic [26:0] ns_prod;

   assign rate_full = 30'(in_data.rate_unit) * 30'(in_data.rate_mant);
   assign ns_prod   = 27'(in_data.time_tenth) * 27'(in_data.time_mant);

   always_comb begin
      data_in                    = '0;
      data_in.status             = in_data.status;
      data_in.high_capacity      = in_data.high_capacity;
      data_in.cap_base           = 23'(in_data.c_size) + 23'd1;
      data_in.cap_shift          = in_data.cap_shift;
      data_in.max_rate           = rate_full;
      data_in.command_classes    = in_data.command_classes;
      data_in.read_len_log2      = in_data.read_len_log2;
      data_in.write_len_log2     = in_data.write_len_log2;
      data_in.write_speed_factor = in_data.write_speed_factor;
      data_in.dsr_present        = in_data.dsr_present;
      if (in_data.high_capacity) begin
         data_in.block_bytes = V2_BLOCK_BYTES;
      end else begin
         data_in.block_bytes   = 16'd1 << in_data.read_len_log2;
         data_in.access_clocks = 15'(in_data.nsac) * NSAC_SCALE;
         // 1 ns unit rounds up; larger units divide by ten exactly
         if (in_data.taac_unit == 3'd0) begin
            data_in.access_ns = 27'(in_data.taac_ceil);
         end else begin
            data_in.access_ns = ns_prod;
         end
      end
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

[rtl/core/sdcsd_assemble.sv]
// Stage 3 of the CSD decoder: capacity shift, error blanking, output register.
// Depends on sdcsd_pkg.
module sdcsd_assemble
   import sdcsd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  s2_type  in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output rsp_type out_data
);

   logic    valid_ff, valid_in;
   rsp_type data_ff, data_in;

   logic [CAP_WIDE_W-1:0] cap_wide;

   // bytes = base << shift; KB = bytes >> 10
   assign cap_wide = CAP_WIDE_W'(in_data.cap_base) << in_data.cap_shift;

   always_comb begin
      data_in = '0;
      data_in.status = in_data.status;
      if (in_data.status == STATUS_OK) begin
         data_in.high_capacity      = in_data.high_capacity;
         data_in.block_bytes        = in_data.block_bytes;
         data_in.capacity_kb        = cap_wide[KB_SHIFT +: 32];
         data_in.access_clocks      = in_data.access_clocks;
         data_in.access_ns          = in_data.access_ns;
         data_in.max_rate           = in_data.max_rate;
         data_in.command_classes    = in_data.command_classes;
         data_in.read_len_log2      = in_data.read_len_log2;
         data_in.write_len_log2     = in_data.write_len_log2;
         data_in.write_speed_factor = in_data.write_speed_factor;
         data_in.dsr_present        = in_data.dsr_present;
      end
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

[rtl/core/sdcsd_checker.sv]
// Port-level checks for the SD CSD decoder, bound to the top level.
// Depends on sd_csd_register_decoder_macros.svh.
`include "sd_csd_register_decoder_macros.svh"

module sdcsd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [63:0] req_csd_high,
   input logic [63:0] req_csd_low,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_status,
   input logic        rsp_high_capacity,
   input logic [15:0] rsp_block_bytes,
   input logic [31:0] rsp_capacity_kb,
   input logic [14:0] rsp_access_clocks,
   input logic [26:0] rsp_access_ns,
   input logic [29:0] rsp_max_rate,
   input logic [11:0] rsp_command_classes,
   input logic [3:0]  rsp_read_len_log2,
   input logic [3:0]  rsp_write_len_log2,
   input logic [2:0]  rsp_write_speed_factor,
   input logic        rsp_dsr_present
);

   // pipeline empties on reset
   `SDCSD_ASSERT_NORST(a_reset_empty, reset |=> !rsp_valid, "response valid after reset")

   // a bad version beat is blanked
   `SDCSD_ASSERT(a_bad_blank, (rsp_valid && rsp_status) |-> (!rsp_high_capacity && rsp_capacity_kb == 32'd0 && rsp_max_rate == 30'd0 && rsp_command_classes == 12'd0), "bad version beat not blanked")

   // high capacity cards: fixed block, no access times
   `SDCSD_ASSERT(a_v2_fixed, (rsp_valid && rsp_high_capacity) |-> (!rsp_status && rsp_block_bytes == 16'd512 && rsp_access_clocks == 15'd0 && rsp_access_ns == 27'd0), "v2 fields wrong")

   // v1 block size follows the read block length code
   `SDCSD_ASSERT(a_v1_block, (rsp_valid && !rsp_status && !rsp_high_capacity) |-> (rsp_block_bytes == (16'd1 << rsp_read_len_log2)), "v1 block size mismatch")

   // stalled response beat holds
   `SDCSD_ASSERT(a_stall_hold, (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_capacity_kb) && $stable(rsp_max_rate) && $stable(rsp_status)), "stalled response changed")

endmodule

bind sd_csd_register_decoder sdcsd_checker u_checker (.*);

[tb/sv/tb.sv]
// Self-checking testbench for sd_csd_register_decoder: directed and random CSD beats,
// each decoded by an in-bench predictor and checked field by field against the responses.
// Depends on sdcsd_pkg and the decoder RTL only.
`timescale 1ns / 1ps

module tb
   import sdcsd_pkg::*;
();

   localparam int HALF_PERIOD_NS = 6;       // 12 ns clock
   localparam int RESET_CYCLES   = 8;
   localparam int RANDOM_ITEMS   = 600;
   localparam int SETTLE_CYCLES  = 12;      // pipeline is three deep, plus margin
   localparam int CYCLE_LIMIT    = 200000;  // far beyond the slowest legal run

   // Reserved structure version codes, not named in the package
   localparam logic [1:0] VER_RSVD2 = 2'd2;
   localparam logic [1:0] VER_RSVD3 = 2'd3;

   // Decode tables: transfer speed unit in bit/s, TAAC unit in ns, value scaled by ten
   localparam logic [31:0] SPEED_UNIT_BPS [0:7] = '{
      32'd10000, 32'd100000, 32'd1000000, 32'd10000000, 32'd0, 32'd0, 32'd0, 32'd0
   };
   localparam logic [31:0] TAAC_UNIT_NS [0:7] = '{
      32'd1, 32'd10, 32'd100, 32'd1000, 32'd10000, 32'd100000, 32'd1000000, 32'd10000000
   };
   localparam logic [31:0] VALUE_X10 [0:15] = '{
      32'd0,  32'd10, 32'd12, 32'd13, 32'd15, 32'd20, 32'd25, 32'd30,
      32'd35, 32'd40, 32'd45, 32'd50, 32'd55, 32'd60, 32'd70, 32'd80
   };

   typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_BURSTY} stall_mode_type;

   // Every input known from time zero
   logic        clock         = 1'b0;
   logic        reset         = 1'b1;
   logic        req_valid     = 1'b0;
   logic [63:0] req_csd_high  = '0;
   logic [63:0] req_csd_low   = '0;
   logic        rsp_stall     = 1'b0;
   logic        req_stall;
   logic        rsp_valid;
   logic        rsp_status;
   logic        rsp_high_capacity;
   logic [15:0] rsp_block_bytes;
   logic [31:0] rsp_capacity_kb;
   logic [14:0] rsp_access_clocks;
   logic [26:0] rsp_access_ns;
   logic [29:0] rsp_max_rate;
   logic [11:0] rsp_command_classes;
   logic [3:0]  rsp_read_len_log2;
   logic [3:0]  rsp_write_len_log2;
   logic [2:0]  rsp_write_speed_factor;
   logic        rsp_dsr_present;

   // Decodes still owed by the block, oldest first
   rsp_type     pending_decodes [$];
   rsp_type     oldest_decode;

   int             mismatches    = 0;
   int             beats_sent    = 0;
   int             beats_checked = 0;
   int             v1_beats      = 0;
   int             v2_beats      = 0;
   int             rsvd_beats    = 0;
   int             burst_left    = 0;
   int             cycle_count   = 0;
   stall_mode_type stall_mode    = STALL_NONE;
   int             mode_left     = 0;

   sd_csd_register_decoder i_dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_csd_high           (req_csd_high),
      .req_csd_low            (req_csd_low),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_status             (rsp_status),
      .rsp_high_capacity      (rsp_high_capacity),
      .rsp_block_bytes        (rsp_block_bytes),
      .rsp_capacity_kb        (rsp_capacity_kb),
      .rsp_access_clocks      (rsp_access_clocks),
      .rsp_access_ns          (rsp_access_ns),
      .rsp_max_rate           (rsp_max_rate),
      .rsp_command_classes    (rsp_command_classes),
      .rsp_read_len_log2      (rsp_read_len_log2),
      .rsp_write_len_log2     (rsp_write_len_log2),
      .rsp_write_speed_factor (rsp_write_speed_factor),
      .rsp_dsr_present        (rsp_dsr_present)
   );

   always #(HALF_PERIOD_NS) clock = ~clock;

   // ---------------------------------------------------------------------
   // Predictor: full decode of one 128-bit CSD, bit 127 = MSB of csd_high.
   // Products are taken at 64 bits (NSAC at 32) and cut to the port width last.
   // ---------------------------------------------------------------------
   function automatic rsp_type decode_csd(input logic [127:0] csd);
      rsp_type     d;
      logic [1:0]  ver;
      logic [7:0]  taac;
      logic [7:0]  nsac;
      logic [7:0]  speed_code;
      logic [3:0]  rd_len;
      logic [63:0] blk;
      logic [63:0] cap;
      logic [63:0] rate;
      logic [63:0] ns;
      d   = '0;
      ver = csd[127:126];
      if (ver != VER_V1 && ver != VER_V2) begin
         // reserved structure: flag only, everything else zero
         d.status = STATUS_BAD_VER;
         return d;
      end
      taac       = csd[119:112];
      nsac       = csd[111:104];
      speed_code = csd[103:96];
      rd_len     = csd[83:80];

      // bit 7 of the access time and speed bytes is reserved and plays no part
      rate = 64'(SPEED_UNIT_BPS[speed_code[2:0]]) * 64'(VALUE_X10[speed_code[6:3]]);

      d.status             = STATUS_OK;
      d.max_rate           = rate[29:0];
      d.command_classes    = csd[95:84];
      d.read_len_log2      = rd_len;
      d.write_len_log2     = csd[25:22];
      d.write_speed_factor = csd[28:26];
      d.dsr_present        = csd[76];

      if (ver == VER_V1) begin
         blk = 64'd1 << rd_len;
         cap = (64'(csd[73:62]) + 64'd1) << (int'(csd[49:47]) + 2);
         cap = (cap * blk) >> 10;
         ns  = 64'(TAAC_UNIT_NS[taac[2:0]]) * 64'(VALUE_X10[taac[6:3]]);
         ns  = (ns + 64'd9) / 64'd10;   // round up to whole ns
         d.high_capacity = 1'b0;
         d.block_bytes   = blk[15:0];
         d.capacity_kb   = cap[31:0];
         d.access_clocks = 15'(32'(nsac) * 32'd100);
         d.access_ns     = ns[26:0];
      end else begin
         // block addressed card: 22-bit C_SIZE, 512 KB per unit
         cap = (64'(csd[69:48]) + 64'd1) * 64'd512;
         d.high_capacity = 1'b1;
         d.block_bytes   = 16'd512;
         d.capacity_kb   = cap[31:0];
         d.access_clocks = '0;
         d.access_ns     = '0;
      end
      return d;
   endfunction

   // Random CSD with the structure version forced
   function automatic logic [127:0] random_csd(input logic [1:0] ver);
      logic [127:0] c;
      c            = {$urandom, $urandom, $urandom, $urandom};
      c[127:126]   = ver;
      return c;
   endfunction

   // ---------------------------------------------------------------------
   // Sender. Called at a falling edge; returns at the falling edge after
   // the beat is taken. Bursts of random length, random gaps between.
   // ---------------------------------------------------------------------
   task automatic send_csd(input logic [127:0] csd);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 6);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
         // now and then a long burst so the block sees back-to-back beats
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 8);
      end
      burst_left--;
      req_valid    <= 1'b1;
      req_csd_high <= csd[127:64];
      req_csd_low  <= csd[63:0];
      // stall is sampled as it stood at the edge
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_decodes.push_back(decode_csd(csd));
      beats_sent++;
      case (csd[127:126])
         VER_V1:  v1_beats++;
         VER_V2:  v2_beats++;
         default: rsvd_beats++;
      endcase
      @(negedge clock);
   endtask

   // Hold the sender off until every owed response has come back
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_decodes.size() != 0);
      burst_left = 0;
   endtask

   // ---------------------------------------------------------------------
   // Response checker: every accepted beat against the oldest prediction.
   // ---------------------------------------------------------------------
   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_decodes.size() == 0) begin
            $error("response beat with no request outstanding");
            mismatches++;
         end else begin
            oldest_decode = pending_decodes.pop_front();
            beats_checked++;
            check_field("status",             oldest_decode.status,             rsp_status);
            check_field("high_capacity",      oldest_decode.high_capacity,
                        rsp_high_capacity);
            check_field("block_bytes",        oldest_decode.block_bytes,        rsp_block_bytes);
            check_field("capacity_kb",        oldest_decode.capacity_kb,        rsp_capacity_kb);
            check_field("access_clocks",      oldest_decode.access_clocks,
                        rsp_access_clocks);
            check_field("access_ns",          oldest_decode.access_ns,          rsp_access_ns);
            check_field("max_rate",           oldest_decode.max_rate,           rsp_max_rate);
            check_field("command_classes",    oldest_decode.command_classes,
                        rsp_command_classes);
            check_field("read_len_log2",      oldest_decode.read_len_log2,
                        rsp_read_len_log2);
            check_field("write_len_log2",     oldest_decode.write_len_log2,
                        rsp_write_len_log2);
            check_field("write_speed_factor", oldest_decode.write_speed_factor,
                        rsp_write_speed_factor);
            check_field("dsr_present",        oldest_decode.dsr_present,        rsp_dsr_present);
         end
      end
   end

   // Receiver back-pressure: modes of random length, including clear stretches
   always @(negedge clock) begin
      if (mode_left == 0) begin
         stall_mode <= stall_mode_type'($urandom_range(0, 3));
         mode_left  <= $urandom_range(5, 60);
      end else begin
         mode_left  <= mode_left - 1;
      end
      case (stall_mode)
         STALL_NONE:  rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
         default:     rsp_stall <= mode_left[2];   // four on, four off
      endcase
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Version 1: field extremes, every access time and speed unit, odd value
   // codes, reserved bit 7 both ways, and value code zero.
   task automatic test_v1_decode();
      logic [127:0] c;
      int           u;
      send_csd('0);
      c = '1;
      c[127:126] = VER_V1;
      send_csd(c);
      // largest capacity: size, size multiplier and read block length at max
      c = random_csd(VER_V1);
      c[73:62] = '1;
      c[49:47] = '1;
      c[83:80] = 4'd15;
      send_csd(c);
      // smallest: one-byte blocks, capacity rounds to zero KB
      c = random_csd(VER_V1);
      c[73:62] = '0;
      c[49:47] = '0;
      c[83:80] = 4'd0;
      send_csd(c);
      // speed units 4..7 are reserved and give no rate
      for (u = 0; u < 8; u++) begin
         c = random_csd(VER_V1);
         c[119:112] = {u[0], 4'(2 * u + 1), 3'(u)};
         c[103:96]  = {~u[0], 4'(15 - 2 * u), 3'(u)};
         send_csd(c);
      end
      c = random_csd(VER_V1);
      c[118:115] = 4'd0;
      c[102:99]  = 4'd0;
      send_csd(c);
   endtask

   // Version 2: fixed block, 22-bit C_SIZE at both ends
   task automatic test_v2_decode();
      logic [127:0] c;
      c = '0;
      c[127:126] = VER_V2;
      send_csd(c);
      c = '1;
      c[127:126] = VER_V2;
      send_csd(c);
      c = random_csd(VER_V2);
      c[69:48] = '0;
      send_csd(c);
   endtask

   // Reserved structure codes: status only
   task automatic test_reserved_version();
      logic [127:0] c;
      c = '0;
      c[127:126] = VER_RSVD2;
      send_csd(c);
      send_csd('1);
      send_csd(random_csd(VER_RSVD2));
      send_csd(random_csd(VER_RSVD3));
   endtask

   // Sender stops dead until the pipe is empty, then restarts
   task automatic test_drain_pause();
      repeat (12) send_csd(random_csd($urandom_range(0, 1) ? VER_V2 : VER_V1));
      wait_for_drain();
      repeat (4) send_csd(random_csd(VER_V1));
   endtask

   // Mostly good versions with random content; a fifth reserved codes
   task automatic test_random_decode();
      int         n;
      int         pick;
      logic [1:0] ver;
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 2) wait_for_drain();
         pick = $urandom_range(0, 9);
         if (pick < 4)       ver = VER_V1;
         else if (pick < 8)  ver = VER_V2;
         else if (pick == 8) ver = VER_RSVD2;
         else                ver = VER_RSVD3;
         send_csd(random_csd(ver));
      end
   endtask

   initial begin
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_v1_decode();
      test_v2_decode();
      test_reserved_version();
      test_drain_pause();
      test_random_decode();

      req_valid <= 1'b0;
      while (pending_decodes.size() != 0) @(posedge clock);
      // catch any stray beat after the last expected one
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Decoded %0d CSD beats (%0d v1, %0d v2, %0d reserved), %0d responses checked.",
               beats_sent, v1_beats, v2_beats, rsvd_beats, beats_checked);
      $display("Sender bursts and gaps, receiver stall modes and one full drain pause exercised.");
      if (mismatches == 0 && pending_decodes.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
